// ===== hdl/cshd_pkg.sv =====
// ----------------------------------------------------------------------------
// cshd_pkg: shared types and constants
// Item format, sequencer states and the Q1.17 half-band coefficient table.
// ----------------------------------------------------------------------------
package cshd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int HALF_TAPS = 31;
	localparam int LINE_W    = 6;
	localparam int LINE_LEN  = 64;
	localparam int MAX_STG   = 8;
	localparam int STG_W     = 4;
	localparam int SIDX_W    = 3;
	localparam int ADDR_W    = SIDX_W + LINE_W;
	localparam int COEF_W    = 18;
	localparam int PAIR_W    = SAMPLE_W + 1;
	localparam int PROD_W    = PAIR_W + COEF_W;
	localparam int ACC_W     = 40;
	localparam int COEF_FRAC = 17;
	localparam int RES_MAX   = 32;
	localparam int RES_W     = 6;
	localparam int REM_W     = 5;
	localparam int TAIL_OUT  = 15;
	localparam int CNT_SAT   = 63;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_INS,
		B_MAC,
		B_EMIT,
		B_DONE,
		B_FCHK,
		B_FRD,
		B_FWAIT,
		B_END
	} bstate_t;

	function automatic logic signed [COEF_W-1:0] coef_at(input logic [4:0] d);
		logic signed [COEF_W-1:0] c;
		unique case (d)
			5'd0:  c = 18'sd60293;
			5'd1:  c = 18'sd41218;
			5'd2:  c = 18'sd5101;
			5'd3:  c = -18'sd12449;
			5'd4:  c = -18'sd4696;
			5'd5:  c = 18'sd6072;
			5'd6:  c = 18'sd4085;
			5'd7:  c = -18'sd3083;
			5'd8:  c = -18'sd3348;
			5'd9:  c = 18'sd1393;
			5'd10: c = 18'sd2576;
			5'd11: c = -18'sd420;
			5'd12: c = -18'sd1849;
			5'd13: c = -18'sd96;
			5'd14: c = 18'sd1228;
			5'd15: c = 18'sd314;
			5'd16: c = -18'sd743;
			5'd17: c = -18'sd352;
			5'd18: c = 18'sd401;
			5'd19: c = 18'sd297;
			5'd20: c = -18'sd185;
			5'd21: c = -18'sd209;
			5'd22: c = 18'sd66;
			5'd23: c = 18'sd126;
			5'd24: c = -18'sd11;
			5'd25: c = -18'sd62;
			5'd26: c = -18'sd5;
			5'd27: c = 18'sd23;
			5'd28: c = 18'sd5;
			5'd29: c = -18'sd5;
			5'd30: c = -18'sd1;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/cshd_ram.sv =====
// ----------------------------------------------------------------------------
// cshd_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cshd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] ra_addr,
	input  logic [$clog2(DEPTH)-1:0] rb_addr,
	output logic [WIDTH-1:0]         ra_data,
	output logic [WIDTH-1:0]         rb_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		ra_data <= mem_q[ra_addr];
		rb_data <= mem_q[rb_addr];
	end

endmodule

// ===== hdl/cshd_front.sv =====
// ----------------------------------------------------------------------------
// cshd_front: input side
// Accept sample beats and queue them for the filter sequencer.
// ----------------------------------------------------------------------------
module cshd_front import cshd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last_sample,
	output logic                       q_valid,
	output item_t                      q_item,
	input  logic                       q_pop
);

	item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;

	assign in_ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{sample: sample, last: last_sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
		end
	end

endmodule

// ===== hdl/cshd_back.sv =====
// ----------------------------------------------------------------------------
// cshd_back: filter sequencer
// Run each sample down the stage cascade on one shared symmetric MAC,
// flush the stages at the end of a record and drive the result register.
// ----------------------------------------------------------------------------
module cshd_back import cshd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [STG_W-1:0]           cfg_data,
	input  logic                       q_valid,
	input  item_t                      q_item,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic                       out_last
);

	bstate_t                    st_q, st_nxt;
	logic [STG_W-1:0]           cfg_q, live;
	logic [STG_W-1:0]           stg_q, fs_q;
	logic [SIDX_W-1:0]          si;
	logic [LINE_W-1:0]          cnt_q [MAX_STG];
	logic                       ph_q  [MAX_STG];
	logic [LINE_W-1:0]          wp_q  [MAX_STG];
	logic signed [SAMPLE_W-1:0] cur_q, hold_q, out_d_q;
	logic                       lst_q, hold_v_q, out_v_q, out_l_q;
	logic [RES_W-1:0]           res_n_q;
	logic                       fact_q;
	logic [REM_W-1:0]           rem_q;
	logic                       fire, out_free;
	logic [LINE_W-1:0]          cnt_inc;

	logic [LINE_W-1:0]          base_q, nv_q;
	logic [4:0]                 d_q;
	logic                       iss_done_q;
	logic                       v_s1, va_s1, vb_s1;
	logic [4:0]                 d_s1;
	logic                       v_s2, v_s3;
	logic signed [PAIR_W-1:0]   pair_s2;
	logic signed [COEF_W-1:0]   coef_s2;
	logic signed [PROD_W-1:0]   prod_s3;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       mac_done;
	logic [LINE_W-1:0]          back_a, back_b;

	logic                       ram_we;
	logic [ADDR_W-1:0]          ram_wa, ram_ra, ram_rb;
	logic [SAMPLE_W-1:0]        ram_da, ram_db;
	logic signed [SAMPLE_W-1:0] rd_a, rd_b;

	logic                       out_load, out_load_last;
	logic signed [SAMPLE_W-1:0] out_load_d;

	logic signed [ACC_W:0]      rnd_v;
	logic signed [ACC_W-COEF_FRAC:0] rnd_q;
	logic signed [SAMPLE_W-1:0] rnd_sat;

	assign live     = (cfg_q > STG_W'(MAX_STG)) ? STG_W'(MAX_STG) : cfg_q;
	assign si       = stg_q[SIDX_W-1:0];
	assign fire     = (cnt_q[si] >= LINE_W'(HALF_TAPS)) && ph_q[si];
	assign cnt_inc  = (cnt_q[si] == LINE_W'(CNT_SAT)) ? cnt_q[si] : cnt_q[si] + 1'b1;
	assign out_free = !out_v_q || out_ready;
	assign mac_done = iss_done_q && !v_s1 && !v_s2 && !v_s3;
	assign back_a   = LINE_W'(HALF_TAPS) - LINE_W'(d_q);
	assign back_b   = LINE_W'(HALF_TAPS) + LINE_W'(d_q);
	assign rd_a     = signed'(ram_da);
	assign rd_b     = signed'(ram_db);

	assign rnd_v   = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (COEF_FRAC - 1));
	assign rnd_q   = rnd_v[ACC_W:COEF_FRAC];
	assign rnd_sat = (rnd_q > (ACC_W-COEF_FRAC+1)'(32767)) ? 16'sh7fff :
		(rnd_q < -(ACC_W-COEF_FRAC+1)'(32768)) ? -16'sh8000 : rnd_q[SAMPLE_W-1:0];

	cshd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_STG * LINE_LEN)) u_line (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_wa),
		.wdata   (cur_q),
		.ra_addr (ram_ra),
		.rb_addr (ram_rb),
		.ra_data (ram_da),
		.rb_data (ram_db)
	);

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			B_IDLE: begin
				if (q_valid) st_nxt = B_INS;
			end
			B_INS: begin
				if (stg_q >= live) st_nxt = B_EMIT;
				else if (fire) st_nxt = B_MAC;
				else st_nxt = B_DONE;
			end
			B_MAC: begin
				if (mac_done) st_nxt = B_INS;
			end
			B_EMIT: begin
				if (res_n_q >= RES_W'(RES_MAX)) st_nxt = B_DONE;
				else if (lst_q && !hold_v_q) st_nxt = B_DONE;
				else if (out_free) st_nxt = B_DONE;
			end
			B_DONE: begin
				st_nxt = lst_q ? B_FCHK : B_IDLE;
			end
			B_FCHK: begin
				if (fs_q >= live) st_nxt = B_END;
				else if (fact_q && rem_q != '0) st_nxt = B_INS;
				else if (!fact_q && cnt_q[si] == LINE_W'(1)) st_nxt = B_FRD;
			end
			B_FRD:   st_nxt = B_FWAIT;
			B_FWAIT: st_nxt = B_INS;
			B_END: begin
				if (!hold_v_q || out_free) st_nxt = B_IDLE;
			end
			default: st_nxt = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop         = 1'b0;
		ram_we        = 1'b0;
		ram_wa        = {si, wp_q[si]};
		ram_ra        = {si, base_q - back_a};
		ram_rb        = {si, base_q - back_b};
		out_load      = 1'b0;
		out_load_last = 1'b0;
		out_load_d    = cur_q;
		unique case (st_q)
			B_IDLE: q_pop = q_valid;
			B_INS:  ram_we = (stg_q < live);
			B_FRD:  ram_ra = {si, wp_q[si] - 1'b1};
			B_EMIT: begin
				if (res_n_q < RES_W'(RES_MAX) && out_free) begin
					if (!lst_q) begin
						out_load = 1'b1;
					end else if (hold_v_q) begin
						out_load   = 1'b1;
						out_load_d = hold_q;
					end
				end
			end
			B_END: begin
				if (hold_v_q && out_free) begin
					out_load      = 1'b1;
					out_load_last = 1'b1;
					out_load_d    = hold_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_d_q <= out_load_d;
			out_l_q <= out_load_last;
		end
		if (st_q == B_IDLE && q_valid) begin
			cur_q <= q_item.sample;
			lst_q <= q_item.last;
		end
		if (st_q == B_INS && fire) begin
			base_q <= wp_q[si];
			nv_q   <= cnt_inc;
		end
		if (st_q == B_MAC && mac_done) cur_q <= rnd_sat;
		if (st_q == B_FCHK && fact_q && rem_q != '0) cur_q <= '0;
		if (st_q == B_FWAIT) cur_q <= rd_a;
		if (st_q == B_EMIT && lst_q && res_n_q < RES_W'(RES_MAX) && (!hold_v_q || out_free)) begin
			hold_q <= cur_q;
		end
		va_s1 <= (back_a < nv_q);
		vb_s1 <= (d_q != '0) && (back_b < nv_q);
		d_s1  <= d_q;
		pair_s2 <= (va_s1 ? PAIR_W'(rd_a) : '0) + (vb_s1 ? PAIR_W'(rd_b) : '0);
		coef_s2 <= coef_at(d_s1);
		prod_s3 <= pair_s2 * coef_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_IDLE;
			cfg_q      <= '0;
			stg_q      <= '0;
			fs_q       <= '0;
			out_v_q    <= 1'b0;
			hold_v_q   <= 1'b0;
			res_n_q    <= '0;
			fact_q     <= 1'b0;
			rem_q      <= '0;
			d_q        <= '0;
			iss_done_q <= 1'b1;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			acc_q      <= '0;
			for (int i = 0; i < MAX_STG; i++) begin
				cnt_q[i] <= '0;
				ph_q[i]  <= 1'b0;
				wp_q[i]  <= '0;
			end
		end else begin
			st_q <= st_nxt;
			if (out_load) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			v_s1 <= (st_q == B_MAC) && !iss_done_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) acc_q <= acc_q + ACC_W'(prod_s3);
			if (cfg_we) begin
				cfg_q <= cfg_data;
				for (int i = 0; i < MAX_STG; i++) begin
					cnt_q[i] <= '0;
					ph_q[i]  <= 1'b0;
					wp_q[i]  <= '0;
				end
			end
			unique case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						stg_q   <= '0;
						fs_q    <= '0;
						res_n_q <= '0;
						fact_q  <= 1'b0;
						rem_q   <= '0;
					end
				end
				B_INS: begin
					if (stg_q < live) begin
						cnt_q[si] <= cnt_inc;
						ph_q[si]  <= !ph_q[si];
						wp_q[si]  <= wp_q[si] + 1'b1;
						if (fire) begin
							d_q        <= '0;
							iss_done_q <= 1'b0;
							acc_q      <= '0;
							if (fact_q && stg_q == fs_q) rem_q <= rem_q - 1'b1;
						end
					end
				end
				B_MAC: begin
					if (!iss_done_q) begin
						d_q <= d_q + 1'b1;
						if (d_q == 5'(HALF_TAPS - 1)) iss_done_q <= 1'b1;
					end
					if (mac_done) stg_q <= stg_q + 1'b1;
				end
				B_EMIT: begin
					if (res_n_q < RES_W'(RES_MAX)) begin
						if (lst_q && !hold_v_q) begin
							hold_v_q <= 1'b1;
							res_n_q  <= res_n_q + 1'b1;
						end else if (out_free) begin
							res_n_q <= res_n_q + 1'b1;
						end
					end
				end
				B_DONE: begin
					if (lst_q) stg_q <= fs_q;
				end
				B_FCHK: begin
					if (fs_q < live) begin
						if (fact_q) begin
							if (rem_q == '0) begin
								cnt_q[si] <= '0;
								ph_q[si]  <= 1'b0;
								wp_q[si]  <= '0;
								fs_q      <= fs_q + 1'b1;
								stg_q     <= stg_q + 1'b1;
								fact_q    <= 1'b0;
							end
						end else if (cnt_q[si] >= LINE_W'(2)) begin
							rem_q  <= (cnt_q[si] >= LINE_W'(HALF_TAPS)) ?
								REM_W'(TAIL_OUT) : cnt_q[si][REM_W:1];
							fact_q <= 1'b1;
						end else if (cnt_q[si] == '0) begin
							fs_q  <= fs_q + 1'b1;
							stg_q <= stg_q + 1'b1;
						end
					end
				end
				B_FWAIT: begin
					cnt_q[si] <= '0;
					ph_q[si]  <= 1'b0;
					wp_q[si]  <= '0;
					fs_q      <= fs_q + 1'b1;
					stg_q     <= stg_q + 1'b1;
				end
				B_END: begin
					if (hold_v_q && out_free) hold_v_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign out_valid  = out_v_q;
	assign out_sample = out_d_q;
	assign out_last   = out_l_q;

	a_mac_live: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_MAC |-> stg_q < live) else $error("MAC on a stage past the cascade");
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> lst_q) else $error("held result outside a record end");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == B_IDLE |-> !hold_v_q) else $error("held result left at idle");
	a_res_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_n_q <= RES_W'(RES_MAX)) else $error("result count past cap");

endmodule

// ===== hdl/cascaded_halfband_decimator.sv =====
// ----------------------------------------------------------------------------
// cascaded_halfband_decimator: cascade of 61-tap half-band decimate-by-2 stages
// A sample runs through the live stages in turn and passes straight to the output when
// none is live. A stage that fires feeds its centre tap and 30 symmetric pairs through
// the shared MAC and lets its pipeline drain. The input queue takes new beats while the
// sequencer works on a sample; record ends add the flush tail.
// Reset clears the stage counts and write pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module cascaded_halfband_decimator import cshd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [STG_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last_sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_sample,
	output logic                       out_last
);

	logic  q_valid, q_pop;
	item_t q_item;

	cshd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.last_sample (last_sample),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	cshd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.out_last   (out_last)
	);

endmodule
